/* rtl/usb_td_trb_builder_and_completion_unit_defines.svh */
// Assertion macros for the TRB builder and completion unit checker.
`ifndef USB_TD_TRB_BUILDER_AND_COMPLETION_UNIT_DEFINES_SVH
`define USB_TD_TRB_BUILDER_AND_COMPLETION_UNIT_DEFINES_SVH

// clocked assertion, off during reset
`define USBTD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// clocked assertion, also checked during reset
`define USBTD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

/* rtl/usbtd_pkg.sv */
// Package: constants, widths and codes of the TRB builder and completion unit.
`timescale 1ns / 1ps
package usbtd_pkg;
    localparam int MAX_PAGES   = 16;
    localparam int PAGE_SIZE   = 4096;
    localparam int ENTRY_DEPTH = MAX_PAGES + 2;
    localparam int CAPACITY    = MAX_PAGES * PAGE_SIZE;
    localparam int PAGE_BITS   = $clog2(PAGE_SIZE);
    localparam int PAGE_IDX_W  = $clog2(MAX_PAGES);
    localparam int ENT_ADDR_W  = $clog2(ENTRY_DEPTH);
    localparam int LEN_W       = 13;
    localparam int OFF_W       = 17;
    localparam int TYPE_W      = 3;
    localparam int ENT_W       = TYPE_W + OFF_W + LEN_W;

    localparam int S_TDATA_W   = 200;
    localparam int M_TDATA_W   = 152;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_BUILD = 2'd1;
    localparam logic [1:0] CMD_EVENT = 2'd2;

    localparam logic [1:0] KIND_TRB     = 2'd0;
    localparam logic [1:0] KIND_REJECT  = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    localparam logic [2:0] TRB_NORMAL = 3'd1;
    localparam logic [2:0] TRB_SETUP  = 3'd2;
    localparam logic [2:0] TRB_DATA   = 3'd3;
    localparam logic [2:0] TRB_STATUS = 3'd4;

    localparam logic [7:0] CODE_SUCCESS = 8'd1;
    localparam logic [7:0] CODE_SHORT   = 8'd13;

    localparam int TYPE_SHIFT = 10;
    localparam int DIR_SHIFT  = 16;
    localparam logic [31:0] F_ISP = 32'h1 << 2;
    localparam logic [31:0] F_CH  = 32'h1 << 4;
    localparam logic [31:0] F_IOC = 32'h1 << 5;
    localparam logic [31:0] F_IDT = 32'h1 << 6;
    localparam logic [4:0]  TD_SIZE_MAX = 5'd31;
    localparam logic [31:0] SETUP_LEN = 32'd8;
endpackage

/* rtl/usbtd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module usbtd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/usb_td_trb_builder_and_completion_unit.sv */
// Top level: TRB builder and completion event decoder for one USB transfer.
//
// Input stream s_*: s_tuser carries the command (load page, build, event),
// s_tdata the operand fields. Output stream m_*: m_tuser is the result kind,
// m_tlast marks the final result of one input command.
// A load writes the page table and gives no result. A build is checked
// first, then emits its TRBs in order: setup (control only), each data
// TRB (page table read plus a 5-step TD-size divider), status (control
// only). A rejected build gives one result. An event reads the entry
// memory and gives its verdict. One command is worked on at a time;
// s_tready is high only between commands.
// A single output register holds each result; while the receiver stalls,
// the sequencer waits in its emit state, state unchanged. Reset clears
// the transfer state and output valid; the page and entry memories are
// undefined until written.
`timescale 1ns / 1ps
module usb_td_trb_builder_and_completion_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // page_index, page_address, setup_packet, total_bytes, is_input,
    // is_control, max_packet, event_index, event_code, residual
    input  logic [usbtd_pkg::S_TDATA_W-1:0]  s_tdata,
    // command
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // trb_parameter, trb_status, trb_control, event_valid, transfer_done,
    // actual_bytes
    output logic [usbtd_pkg::M_TDATA_W-1:0]  m_tdata,
    // result_kind
    output logic [1:0]                        m_tuser,
    output logic                              m_tlast
);
    import usbtd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_REJECT, ST_SETUP, ST_DSTART, ST_DIV,
        ST_DEMIT, ST_STATUS, ST_EVWAIT, ST_EVEMIT
    } state_t;

    state_t state_reg;

    logic [PAGE_IDX_W-1:0] in_page_idx;
    logic [63:0]           in_page_addr;
    logic [63:0]           in_setup;
    logic [16:0]           in_bytes;
    logic                  in_input;
    logic                  in_control;
    logic [10:0]           in_mp;
    logic [4:0]            in_evidx;
    logic [7:0]            in_code;
    logic [23:0]           in_res;

    assign in_page_idx  = s_tdata[3:0];
    assign in_page_addr = s_tdata[67:4];
    assign in_setup     = s_tdata[131:68];
    assign in_bytes     = s_tdata[148:132];
    assign in_input     = s_tdata[149];
    assign in_control   = s_tdata[150];
    assign in_mp        = s_tdata[161:151];
    assign in_evidx     = s_tdata[166:162];
    assign in_code      = s_tdata[174:167];
    assign in_res       = s_tdata[198:175];

    logic [63:0] setup_reg;
    logic [16:0] bytes_reg;
    logic        ctrl_reg, inp_reg;
    logic [10:0] mp_reg;
    logic [4:0]  idx_reg;
    logic [7:0]  code_reg;
    logic [23:0] res_reg;

    logic [4:0]       n_reg;
    logic [OFF_W-1:0] off_reg;
    logic [LEN_W-1:0] len_reg;
    logic             final_reg;
    logic [17:0]      rem_reg;
    logic [4:0]       q_reg;
    logic [2:0]       step_reg;
    logic             force_reg;
    logic [4:0]       force_val_reg;
    logic [PAGE_IDX_W-1:0] page_reg;
    logic [ENT_ADDR_W-1:0] ent_raddr_reg;

    logic [4:0]  count_reg;
    logic        short_seen_reg;
    logic [16:0] short_act_reg;
    logic [16:0] built_bytes_reg;
    logic        built_in_reg, built_ctl_reg;

    logic        m_valid_reg;
    logic [1:0]  kind_reg;
    logic [63:0] param_reg;
    logic [31:0] stat_reg, ctl_reg;
    logic        last_reg, evv_reg, done_reg;
    logic [16:0] act_reg;

    logic [63:0]       page_rdata;
    logic [ENT_W-1:0]  ent_rdata;
    logic              ent_we;
    logic [ENT_W-1:0]  ent_wdata;
    logic              page_we;

    usbtd_ram #(.WIDTH(64), .DEPTH(MAX_PAGES)) u_page_ram (
        .aclk (aclk),
        .we   (page_we),
        .waddr(in_page_idx),
        .wdata(in_page_addr),
        .raddr(page_reg),
        .rdata(page_rdata)
    );

    usbtd_ram #(.WIDTH(ENT_W), .DEPTH(ENTRY_DEPTH)) u_entry_ram (
        .aclk (aclk),
        .we   (ent_we),
        .waddr(n_reg[ENT_ADDR_W-1:0]),
        .wdata(ent_wdata),
        .raddr(ent_raddr_reg),
        .rdata(ent_rdata)
    );

    logic out_free, s_fire, out_load;
    assign out_free = !m_valid_reg || m_tready;
    assign out_load = out_free && ((state_reg == ST_REJECT) || (state_reg == ST_SETUP) ||
                                   (state_reg == ST_DEMIT) || (state_reg == ST_STATUS) ||
                                   (state_reg == ST_EVEMIT));
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign page_we  = s_fire && (s_tuser == CMD_LOAD);

    // build check
    logic reject;
    assign reject = (32'(bytes_reg) > CAPACITY) ||
                    (ctrl_reg && (bytes_reg != {1'b0, setup_reg[63:48]})) ||
                    (!ctrl_reg && (bytes_reg == 17'd0));

    // data chunk setup
    logic [16:0]      remaining, rest;
    logic [LEN_W-1:0] chunk_len;
    logic             chunk_final;
    logic [15:0]      mp31;
    logic [17:0]      numer;
    assign remaining   = bytes_reg - off_reg;
    assign chunk_final = (32'(remaining) <= PAGE_SIZE);
    assign chunk_len   = chunk_final ? remaining[LEN_W-1:0] : LEN_W'(PAGE_SIZE);
    assign rest        = remaining - 17'(chunk_len);
    assign mp31        = {mp_reg, 5'd0} - 16'(mp_reg);
    assign numer       = 18'(rest) + 18'(mp_reg) - 18'd1;

    logic [17:0] div_d;
    logic        div_ge;
    assign div_d  = 18'(mp_reg) << step_reg;
    assign div_ge = rem_reg >= div_d;

    // TRB words
    logic [2:0]  d_type;
    logic [4:0]  packets;
    logic [31:0] d_ctl, setup_ctl, status_ctl;
    assign d_type  = (ctrl_reg && off_reg == '0) ? TRB_DATA : TRB_NORMAL;
    assign packets = force_reg ? force_val_reg : q_reg;
    assign d_ctl = (32'(d_type) << TYPE_SHIFT) |
                   (!final_reg ? F_CH : (!ctrl_reg ? F_IOC : 32'd0)) |
                   (inp_reg ? F_ISP : 32'd0) |
                   ((d_type == TRB_DATA && inp_reg) ? (32'd1 << DIR_SHIFT) : 32'd0);
    assign setup_ctl = (32'(TRB_SETUP) << TYPE_SHIFT) | F_IDT |
                       ((bytes_reg != 17'd0) ?
                        ((inp_reg ? 32'd3 : 32'd2) << DIR_SHIFT) : 32'd0);
    assign status_ctl = (32'(TRB_STATUS) << TYPE_SHIFT) | F_IOC |
                        ((!inp_reg || bytes_reg == 17'd0) ? (32'd1 << DIR_SHIFT) : 32'd0);

    always_comb begin
        ent_we    = 1'b0;
        ent_wdata = {d_type, off_reg, len_reg};
        case (state_reg)
            ST_SETUP: begin
                ent_we    = out_free;
                ent_wdata = {TRB_SETUP, OFF_W'(0), LEN_W'(0)};
            end
            ST_DEMIT: begin
                ent_we    = out_free;
            end
            ST_STATUS: begin
                ent_we    = out_free;
                ent_wdata = {TRB_STATUS, OFF_W'(0), LEN_W'(0)};
            end
            default: ;
        endcase
    end

    // event verdict
    logic [TYPE_W-1:0] e_type;
    logic [OFF_W-1:0]  e_off;
    logic [LEN_W-1:0]  e_len;
    logic [24:0]       e_sum;
    logic              first_short, bad0, bad1, bad2, ev_ok, ev_done;
    logic [16:0]       ev_act, sh_act;
    assign e_type = ent_rdata[ENT_W-1 -: TYPE_W];
    assign e_off  = ent_rdata[LEN_W +: OFF_W];
    assign e_len  = ent_rdata[LEN_W-1:0];
    assign e_sum  = 25'(e_off) + 25'(e_len) - 25'(res_reg);
    assign first_short = (code_reg == CODE_SHORT) && !short_seen_reg;
    assign bad0 = (idx_reg >= count_reg) ||
                  ((code_reg != CODE_SUCCESS) && (code_reg != CODE_SHORT)) ||
                  ((code_reg == CODE_SUCCESS) && (res_reg != 24'd0));
    assign bad1 = first_short && (!built_in_reg || e_len == '0 ||
                  res_reg > 24'(e_len) || e_sum > 25'(built_bytes_reg));
    assign sh_act = first_short ? e_sum[16:0] : short_act_reg;
    assign ev_act = (short_seen_reg || first_short) ? sh_act : built_bytes_reg;
    assign bad2   = ev_act > built_bytes_reg;
    assign ev_ok  = !(bad0 || bad1 || bad2);
    assign ev_done = built_ctl_reg ? (e_type == TRB_STATUS) :
                     ((code_reg == CODE_SHORT) || (idx_reg + 5'd1 == count_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            count_reg       <= '0;
            short_seen_reg  <= 1'b0;
            short_act_reg   <= '0;
            built_bytes_reg <= '0;
            built_in_reg    <= 1'b0;
            built_ctl_reg   <= 1'b0;
        end else begin
            if (m_tready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        setup_reg     <= in_setup;
                        bytes_reg     <= in_bytes;
                        ctrl_reg      <= in_control;
                        inp_reg       <= in_control ? in_setup[7] : in_input;
                        mp_reg        <= in_mp;
                        idx_reg       <= in_evidx;
                        code_reg      <= in_code;
                        res_reg       <= in_res;
                        ent_raddr_reg <= (32'(in_evidx) < ENTRY_DEPTH) ?
                                         in_evidx[ENT_ADDR_W-1:0] : '0;
                        case (s_tuser)
                            CMD_BUILD: state_reg <= ST_CHECK;
                            CMD_EVENT: state_reg <= ST_EVWAIT;
                            default:   state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_CHECK: begin
                    if (reject) begin
                        state_reg <= ST_REJECT;
                    end else begin
                        short_seen_reg  <= 1'b0;
                        short_act_reg   <= '0;
                        built_bytes_reg <= bytes_reg;
                        built_in_reg    <= inp_reg;
                        built_ctl_reg   <= ctrl_reg;
                        n_reg           <= '0;
                        off_reg         <= '0;
                        state_reg       <= ctrl_reg ? ST_SETUP : ST_DSTART;
                    end
                end
                ST_REJECT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        kind_reg    <= KIND_REJECT;
                        param_reg   <= '0;
                        stat_reg    <= '0;
                        ctl_reg     <= '0;
                        last_reg    <= 1'b1;
                        evv_reg     <= 1'b0;
                        done_reg    <= 1'b0;
                        act_reg     <= '0;
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_SETUP: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        kind_reg    <= KIND_TRB;
                        param_reg   <= setup_reg;
                        stat_reg    <= SETUP_LEN;
                        ctl_reg     <= setup_ctl;
                        last_reg    <= 1'b0;
                        evv_reg     <= 1'b0;
                        done_reg    <= 1'b0;
                        act_reg     <= '0;
                        n_reg       <= n_reg + 5'd1;
                        state_reg   <= (bytes_reg != 17'd0) ? ST_DSTART : ST_STATUS;
                    end
                end
                ST_DSTART: begin
                    page_reg  <= off_reg[PAGE_BITS +: PAGE_IDX_W];
                    len_reg   <= chunk_len;
                    final_reg <= chunk_final;
                    rem_reg   <= numer;
                    q_reg     <= '0;
                    step_reg  <= 3'd4;
                    if (mp_reg == 11'd0) begin
                        force_reg     <= 1'b1;
                        force_val_reg <= (rest != 17'd0) ? TD_SIZE_MAX : 5'd0;
                    end else begin
                        force_reg     <= (rest > 17'(mp31));
                        force_val_reg <= TD_SIZE_MAX;
                    end
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_ge) begin
                        rem_reg <= rem_reg - div_d;
                    end
                    q_reg <= {q_reg[3:0], div_ge};
                    if (step_reg == 3'd0) begin
                        state_reg <= ST_DEMIT;
                    end else begin
                        step_reg <= step_reg - 3'd1;
                    end
                end
                ST_DEMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        kind_reg    <= KIND_TRB;
                        param_reg   <= page_rdata;
                        stat_reg    <= {10'd0, packets, 4'd0, len_reg};
                        ctl_reg     <= d_ctl;
                        last_reg    <= final_reg && !ctrl_reg;
                        evv_reg     <= 1'b0;
                        done_reg    <= 1'b0;
                        act_reg     <= '0;
                        n_reg       <= n_reg + 5'd1;
                        off_reg     <= off_reg + OFF_W'(len_reg);
                        if (!final_reg) begin
                            state_reg <= ST_DSTART;
                        end else if (ctrl_reg) begin
                            state_reg <= ST_STATUS;
                        end else begin
                            count_reg <= n_reg + 5'd1;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_STATUS: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        kind_reg    <= KIND_TRB;
                        param_reg   <= '0;
                        stat_reg    <= '0;
                        ctl_reg     <= status_ctl;
                        last_reg    <= 1'b1;
                        evv_reg     <= 1'b0;
                        done_reg    <= 1'b0;
                        act_reg     <= '0;
                        count_reg   <= n_reg + 5'd1;
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_EVWAIT: begin
                    state_reg <= ST_EVEMIT;
                end
                ST_EVEMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        kind_reg    <= KIND_VERDICT;
                        param_reg   <= '0;
                        stat_reg    <= '0;
                        ctl_reg     <= '0;
                        last_reg    <= 1'b1;
                        evv_reg     <= ev_ok;
                        done_reg    <= ev_ok && ev_done;
                        act_reg     <= ev_ok ? ev_act : 17'd0;
                        if (ev_ok && first_short) begin
                            short_seen_reg <= 1'b1;
                            short_act_reg  <= sh_act;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {5'd0, act_reg, done_reg, evv_reg, ctl_reg, stat_reg, param_reg};
endmodule

/* rtl/usbtd_checker.sv */
// Port checker for the TRB builder and completion unit, with its bind.
`timescale 1ns / 1ps
`include "usb_td_trb_builder_and_completion_unit_defines.svh"
module usbtd_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [usbtd_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [1:0]                       s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [usbtd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [1:0]                       m_tuser,
    input logic                             m_tlast
);
    import usbtd_pkg::*;

    `USBTD_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid, "output valid after reset")
    `USBTD_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled transfer changed")
    `USBTD_ASSERT(a_single_last, m_tvalid && m_tuser != KIND_TRB |-> m_tlast, "reject or verdict not last")
    `USBTD_ASSERT(a_verdict_zero, m_tvalid && m_tuser != KIND_TRB |-> m_tdata[127:0] == 128'd0, "nonzero TRB words on verdict")
    `USBTD_ASSERT(a_busy_out, m_tvalid && m_tuser == KIND_TRB && !m_tlast |-> !s_tready, "input ready mid build")
endmodule

bind usb_td_trb_builder_and_completion_unit usbtd_checker u_usbtd_checker (.*);

/* dv/tb_top.sv */
// Testbench for the TRB builder and completion unit: random and directed stream traffic, checked against a built-in predictor.
`timescale 1ns / 1ps
module tb_top;
    import usbtd_pkg::*;

    typedef struct packed {
        logic        pad;
        logic [23:0] residual;
        logic [7:0]  event_code;
        logic [4:0]  event_index;
        logic [10:0] max_packet;
        logic        is_control;
        logic        is_input;
        logic [16:0] total_bytes;
        logic [63:0] setup_packet;
        logic [63:0] page_address;
        logic [3:0]  page_index;
    } cmd_fields_t;

    typedef struct packed {
        logic [4:0]  pad;
        logic [16:0] actual_bytes;
        logic        transfer_done;
        logic        event_valid;
        logic [31:0] trb_control;
        logic [31:0] trb_status;
        logic [63:0] trb_parameter;
    } res_fields_t;

    typedef struct {
        logic [1:0]  cmd;
        cmd_fields_t f;
    } cmd_item_t;

    typedef struct {
        logic [1:0]  kind;
        logic        last;
        res_fields_t f;
    } res_item_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;
    logic m_tlast;

    usb_td_trb_builder_and_completion_unit u_dut (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    cmd_item_t pending_cmds[$];
    res_item_t expected_results[$];
    int accepted_cmds = 0;
    int mismatches = 0;
    int tx_idle_pct = 30;
    int rx_idle_pct = 55;
    int hold_cycles = 0;
    bit hold_done = 0;
    bit pause_tx = 0;
    bit pause_done = 0;
    logic s_acc = 0;

    // predictor state
    logic [63:0] pg_addr[MAX_PAGES];
    logic [2:0]  ent_type[ENTRY_DEPTH];
    int          ent_off[ENTRY_DEPTH];
    int          ent_len[ENTRY_DEPTH];
    int          ent_count = 0;
    bit          short_seen = 0;
    int          short_actual = 0;
    int          built_bytes = 0;
    bit          built_input = 0;
    bit          built_control = 0;

    function automatic void push_result(logic [1:0] kind, logic [63:0] prm, logic [31:0] st,
                                        logic [31:0] ctl, bit vld, bit dn, int act,
                                        bit lst);
        res_item_t r;
        r.kind = kind;
        r.last = lst;
        r.f = '0;
        r.f.trb_parameter = prm;
        r.f.trb_status = st;
        r.f.trb_control = ctl;
        r.f.event_valid = vld;
        r.f.transfer_done = dn;
        r.f.actual_bytes = act[16:0];
        expected_results.push_back(r);
    endfunction

    function automatic void predict_build(cmd_fields_t f);
        int bytes, mp, n, off, rem, len, rest, pkts, pg;
        bit ctl_xfer, dir_in, fin;
        logic [2:0] ty;
        logic [31:0] ctl;
        logic [63:0] addr;
        res_item_t q[$];
        bytes = f.total_bytes;
        ctl_xfer = f.is_control;
        dir_in = ctl_xfer ? f.setup_packet[7] : f.is_input;
        mp = f.max_packet;
        n = 0;
        off = 0;
        if (bytes > CAPACITY || (ctl_xfer && bytes != int'(f.setup_packet[63:48])) ||
            (!ctl_xfer && bytes == 0)) begin
            push_result(KIND_REJECT, 0, 0, 0, 0, 0, 0, 1);
            return;
        end
        if (ctl_xfer) begin
            ent_type[n] = TRB_SETUP;
            ent_off[n] = 0;
            ent_len[n] = 0;
            ctl = (32'(TRB_SETUP) << TYPE_SHIFT) | F_IDT |
                  (bytes != 0 ? (dir_in ? 32'd3 : 32'd2) << DIR_SHIFT : 32'd0);
            push_result(KIND_TRB, f.setup_packet, SETUP_LEN, ctl, 0, 0, 0, 0);
            n++;
        end
        while (off < bytes && n < ENTRY_DEPTH) begin
            rem = bytes - off;
            len = rem < PAGE_SIZE ? rem : PAGE_SIZE;
            fin = (len == rem);
            ty = (ctl_xfer && off == 0) ? TRB_DATA : TRB_NORMAL;
            rest = rem - len;
            pg = off / PAGE_SIZE;
            addr = pg < MAX_PAGES ? pg_addr[pg] : 64'd0;
            if (mp == 0) pkts = rest != 0 ? 31 : 0;
            else pkts = (rest + mp - 1) / mp;
            if (pkts > 31) pkts = 31;
            ctl = (32'(ty) << TYPE_SHIFT) | (!fin ? F_CH : (!ctl_xfer ? F_IOC : 32'd0)) |
                  (dir_in ? F_ISP : 32'd0) |
                  ((ty == TRB_DATA && dir_in) ? 32'd1 << DIR_SHIFT : 32'd0);
            ent_type[n] = ty;
            ent_off[n] = off;
            ent_len[n] = len;
            push_result(KIND_TRB, addr, 32'(len) | (32'(pkts) << 17), ctl, 0, 0, 0, 0);
            n++;
            off += len;
        end
        if (ctl_xfer && n < ENTRY_DEPTH) begin
            ent_type[n] = TRB_STATUS;
            ent_off[n] = 0;
            ent_len[n] = 0;
            ctl = (32'(TRB_STATUS) << TYPE_SHIFT) | F_IOC |
                  ((!dir_in || bytes == 0) ? 32'd1 << DIR_SHIFT : 32'd0);
            push_result(KIND_TRB, 0, 0, ctl, 0, 0, 0, 0);
            n++;
        end
        ent_count = n;
        short_seen = 0;
        short_actual = 0;
        built_bytes = bytes;
        built_input = dir_in;
        built_control = ctl_xfer;
        expected_results[$].last = 1;
    endfunction

    function automatic void predict_event(cmd_fields_t f);
        int idx, res, act;
        bit dn;
        idx = f.event_index;
        res = f.residual;
        if (idx >= ent_count || (f.event_code != CODE_SUCCESS && f.event_code != CODE_SHORT) ||
            (f.event_code == CODE_SUCCESS && res != 0)) begin
            push_result(KIND_VERDICT, 0, 0, 0, 0, 0, 0, 1);
            return;
        end
        if (f.event_code == CODE_SHORT && !short_seen) begin
            if (!built_input || ent_len[idx] == 0 || res > ent_len[idx]) begin
                push_result(KIND_VERDICT, 0, 0, 0, 0, 0, 0, 1);
                return;
            end
            act = ent_off[idx] + ent_len[idx] - res;
            if (act > built_bytes) begin
                push_result(KIND_VERDICT, 0, 0, 0, 0, 0, 0, 1);
                return;
            end
            short_actual = act;
            short_seen = 1;
        end
        act = short_seen ? short_actual : built_bytes;
        if (act > built_bytes) begin
            push_result(KIND_VERDICT, 0, 0, 0, 0, 0, 0, 1);
            return;
        end
        dn = built_control ? (ent_type[idx] == TRB_STATUS) :
             (f.event_code == CODE_SHORT || idx + 1 == ent_count);
        push_result(KIND_VERDICT, 0, 0, 0, 1, dn, act, 1);
    endfunction

    function automatic void predict_command(logic [1:0] cmd, cmd_fields_t f);
        case (cmd)
            CMD_LOAD: pg_addr[f.page_index] = f.page_address;
            CMD_BUILD: predict_build(f);
            CMD_EVENT: predict_event(f);
            default: ;
        endcase
    endfunction

    // sender
    always @(negedge aclk) begin
        cmd_item_t it;
        if (aresetn && (!s_tvalid || s_acc)) begin
            if (pending_cmds.size() > 0 && !(pause_tx && expected_results.size() > 0) &&
                $urandom_range(99) >= tx_idle_pct) begin
                it = pending_cmds.pop_front();
                s_tvalid <= 1;
                s_tuser <= it.cmd;
                s_tdata <= it.f;
            end else begin
                s_tvalid <= 0;
            end
        end
        m_tready <= aresetn && hold_cycles == 0 && $urandom_range(99) >= rx_idle_pct;
    end

    always @(posedge aclk) begin
        s_acc <= s_tvalid && s_tready;
        if (s_tvalid && s_tready) begin
            predict_command(s_tuser, cmd_fields_t'(s_tdata));
            accepted_cmds <= accepted_cmds + 1;
        end
    end

    // phases, long receiver hold-off, sender pause
    always @(posedge aclk) begin
        tx_idle_pct <= accepted_cmds < 160 ? 30 : accepted_cmds < 320 ? 55 : 0;
        rx_idle_pct <= accepted_cmds < 160 ? 55 : accepted_cmds < 320 ? 30 : 0;
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
        else if (!hold_done && accepted_cmds >= 100) begin
            hold_cycles <= 400;
            hold_done <= 1;
        end
        if (!pause_done && accepted_cmds >= 250) begin
            pause_tx <= 1;
            pause_done <= 1;
        end else if (pause_tx && expected_results.size() == 0) begin
            pause_tx <= 0;
        end
    end

    // result checker
    always @(posedge aclk) begin
        res_item_t e;
        res_fields_t a;
        if (aresetn && m_tvalid && m_tready) begin
            a = res_fields_t'(m_tdata);
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: kind %0d data %h",
                                               m_tuser, m_tdata);
            end else begin
                e = expected_results.pop_front();
                if (m_tuser !== e.kind || m_tlast !== e.last ||
                    a.trb_parameter !== e.f.trb_parameter ||
                    a.trb_status !== e.f.trb_status || a.trb_control !== e.f.trb_control ||
                    a.event_valid !== e.f.event_valid ||
                    a.transfer_done !== e.f.transfer_done ||
                    a.actual_bytes !== e.f.actual_bytes) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp: kind %0d last %0d par %h st %h ctl %h v%0d d%0d act %0d",
                                 e.kind, e.last, e.f.trb_parameter, e.f.trb_status,
                                 e.f.trb_control, e.f.event_valid, e.f.transfer_done,
                                 e.f.actual_bytes);
                        $display("         act: kind %0d last %0d par %h st %h ctl %h v%0d d%0d act %0d",
                                 m_tuser, m_tlast, a.trb_parameter, a.trb_status,
                                 a.trb_control, a.event_valid, a.transfer_done,
                                 a.actual_bytes);
                    end
                end
            end
        end
    end

    function automatic cmd_item_t mk(logic [1:0] cmd);
        cmd_item_t it;
        it.cmd = cmd;
        it.f = '0;
        it.f.max_packet = 11'd512;
        return it;
    endfunction

    task automatic add_build(int bytes, bit ctl_xfer, bit dir_in, int mp, bit match_len);
        cmd_item_t it;
        it = mk(CMD_BUILD);
        it.f.total_bytes = bytes[16:0];
        it.f.is_control = ctl_xfer;
        it.f.is_input = dir_in;
        it.f.max_packet = mp[10:0];
        it.f.setup_packet = {$urandom, $urandom};
        if (match_len) it.f.setup_packet[63:48] = bytes[15:0];
        pending_cmds.push_back(it);
    endtask

    task automatic add_event(int idx, logic [7:0] code, int res);
        cmd_item_t it;
        it = mk(CMD_EVENT);
        it.f.event_index = idx[4:0];
        it.f.event_code = code;
        it.f.residual = res[23:0];
        pending_cmds.push_back(it);
    endtask

    task automatic gen_stimulus();
        cmd_item_t it;
        int bytes, ntrb, k, r, mp;
        bit c;
        for (int p = 0; p < MAX_PAGES; p++) begin
            it = mk(CMD_LOAD);
            it.f.page_index = p[3:0];
            it.f.page_address = p == 0 ? 64'd0 : p == 1 ? '1 : {$urandom, $urandom};
            pending_cmds.push_back(it);
        end
        add_event(0, CODE_SUCCESS, 0);
        add_build(1, 0, 1, 1024, 0);
        add_event(0, CODE_SHORT, 1);
        add_build(CAPACITY, 0, 0, 1, 0);
        add_event(15, CODE_SUCCESS, 0);
        add_event(3, CODE_SHORT, 10);
        add_build(0, 0, 1, 64, 0);
        add_build(CAPACITY + 1, 0, 1, 64, 0);
        add_build(100, 1, 0, 64, 0);
        add_build(0, 1, 0, 0, 1);
        add_event(1, CODE_SUCCESS, 0);
        add_build(5000, 1, 1, 0, 1);
        add_event(1, CODE_SHORT, 4096);
        add_event(2, CODE_SHORT, 3);
        add_event(3, CODE_SUCCESS, 0);
        add_event(31, 8'hFF, 24'hFFFFFF);
        add_event(1, CODE_SUCCESS, 5);
        it = mk(2'd3);
        it.f = '1;
        pending_cmds.push_back(it);
        ntrb = 4;
        while (pending_cmds.size() < 460) begin
            r = $urandom_range(99);
            if (r < 5) begin
                it = mk($urandom_range(9) == 0 ? 2'd3 : CMD_LOAD);
                it.f = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
                pending_cmds.push_back(it);
            end else if (r < 35) begin
                k = $urandom_range(99);
                bytes = k < 60 ? $urandom_range(1, 9000) :
                        k < 75 ? PAGE_SIZE * $urandom_range(1, 4) :
                        k < 82 ? CAPACITY - $urandom_range(0, 1) :
                        k < 90 ? $urandom_range(0, 3) : $urandom_range(CAPACITY, 131071);
                c = $urandom_range(2) == 0;
                k = $urandom_range(9);
                mp = k < 6 ? (8 << $urandom_range(7)) : $urandom_range(2047);
                add_build(bytes, c, $urandom_range(1), mp, $urandom_range(9) != 0);
                ntrb = (bytes + PAGE_SIZE - 1) / PAGE_SIZE + (c ? 2 : 0);
                if (ntrb > ENTRY_DEPTH) ntrb = ENTRY_DEPTH;
                if (ntrb == 0) ntrb = 1;
            end else begin
                k = $urandom_range(99);
                add_event(k < 85 ? $urandom_range(ntrb - 1) : $urandom_range(31),
                          k < 50 ? CODE_SUCCESS : k < 90 ? CODE_SHORT : 8'($urandom),
                          $urandom_range(9) < 6 ? (k < 50 ? 0 : $urandom_range(4096)) :
                                                  $urandom_range(24'hFFFFFF));
            end
        end
    endtask

    initial begin
        gen_stimulus();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        wait (pending_cmds.size() == 0 && !s_tvalid);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
